// ----- rtl/btsv_pkg.sv -----
//==============================================================================
// btsv_pkg: shared definitions for the binding table stream validator
// Status codes, configuration register indexes, sequencer states and defaults.
//==============================================================================
`default_nettype none

package btsv_pkg;

    // Default number of binding entries in a table
    localparam int DEFAULT_ENTRY_COUNT = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_CATALOG = 1'd1;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SIZE     = 3'd1;
    localparam logic [2:0] ST_VERSION  = 3'd2;
    localparam logic [2:0] ST_CATALOG  = 3'd3;
    localparam logic [2:0] ST_COUNT    = 3'd4;
    localparam logic [2:0] ST_RESERVED = 3'd5;
    localparam logic [2:0] ST_ORDINAL  = 3'd6;
    localparam logic [2:0] ST_INDEX    = 3'd7;

    // Header byte positions at which a field is complete
    localparam logic [7:0] POS_VERSION   = 8'd1;
    localparam logic [7:0] POS_CATALOG   = 8'd3;
    localparam logic [7:0] POS_COUNT     = 8'd7;
    localparam logic [7:0] POS_RESERVED0 = 8'd11;
    localparam logic [7:0] POS_RESERVED1 = 8'd15;
    localparam logic [7:0] POS_ENTRIES   = 8'd16;
    localparam logic [7:0] POS_MAX       = 8'd255;

    // Byte offsets inside one entry
    localparam logic [2:0] OFF_ORDINAL_END = 3'd3;
    localparam logic [2:0] OFF_IMPORT_END  = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_WRITE,
        S_VERDICT,
        S_ORD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/btsv_ram.sv -----
//==============================================================================
// btsv_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
//==============================================================================
`default_nettype none

module btsv_ram #(
    parameter  int DATA_W = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/binding_table_stream_validator_top.sv -----
//==============================================================================
// binding_table_stream_validator_top: binding table stream validator
// Assembles a little-endian table byte by byte, checks header, ordinals and
// imports with one shared comparator, and reports a verdict on the final byte.
//==============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one table byte per
//   transaction, with i_final_byte on the last byte of the table. The output
//   channel (o_out_valid / i_out_ready) carries results: on an error one
//   transaction with the status code and o_last_result set; on success
//   ENTRY_COUNT transactions, one per import, the last one flagged.
//   Header and ordinal bytes are taken in idle. The last byte of the
//   import of entry i passes S_RD and S_CMP once for each of the i earlier
//   imports, since the single equality comparator walks them out of the
//   import RAM (RAM read, then compare), then S_WRITE. A final byte adds
//   S_VERDICT; on success each result passes S_ORD (RAM read), S_OUT (load).
//   o_in_ready is high only while the sequencer is idle.
//   Reset clears the sequencer, byte counter, error flags, output valid and
//   the expected version/catalog registers; the import RAM is not cleared.
//   When the receiver stalls, the output register holds its result; the
//   block still accepts bytes until it needs to load the next result.
//   Configuration writes (i_cfg_we) take effect at once; write only when idle.
//==============================================================================
`default_nettype none

module binding_table_stream_validator_top #(
    parameter int ENTRY_COUNT = btsv_pkg::DEFAULT_ENTRY_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input byte channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_final_byte,
    // Result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [2:0]                     o_status,
    output logic      [3:0]                     o_entry_ordinal,
    output logic      [31:0]                    o_import_value,
    output logic                                o_last_result,
    // Configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [btsv_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [btsv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW          = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int TABLE_BYTES = 16 + 8 * ENTRY_COUNT;

    localparam logic [15:0]   TABLE_BYTES_W = 16'(TABLE_BYTES);
    localparam logic [7:0]    ENTRY_COUNT_B = 8'(ENTRY_COUNT);
    localparam logic [31:0]   ENTRY_COUNT_W = 32'(ENTRY_COUNT);
    localparam logic [AW-1:0] LAST_ENTRY    = AW'(ENTRY_COUNT - 1);

    // Sequencer and datapath registers
    btsv_pkg::t_state r_state, n_state;
    logic [7:0]    r_pos,        n_pos;
    logic [31:0]   r_shift,      n_shift;
    logic [2:0]    r_first_err,  n_first_err;
    logic          r_imp_err,    n_imp_err;
    logic [31:0]   r_word,       n_word;
    logic [AW-1:0] r_entry,      n_entry;
    logic [AW-1:0] r_j,          n_j;
    logic [AW-1:0] r_k,          n_k;
    logic          r_fin,        n_fin;
    logic          r_out_valid,  n_out_valid;
    logic [2:0]    r_out_status, n_out_status;
    logic [3:0]    r_out_ord,    n_out_ord;
    logic [31:0]   r_out_value,  n_out_value;
    logic          r_out_last,   n_out_last;
    logic [15:0]   r_exp_version;
    logic [15:0]   r_exp_catalog;

    // RAM port signals
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [AW-1:0] w_ram_raddr;
    logic [31:0]   w_ram_rdata;

    // Shared comparator
    logic [31:0]   w_cmp_a;
    logic [31:0]   w_cmp_b;
    logic          w_cmp_eq;

    // Byte decode
    logic          w_accept;
    logic          w_out_free;
    logic          w_in_table;
    logic [31:0]   w_next_shift;
    logic [7:0]    w_q;
    logic [7:0]    w_entry;
    logic [2:0]    w_off;
    logic          w_entry_ok;
    logic          w_chk_en;
    logic [2:0]    w_chk_code;
    logic [AW:0]   w_j_next;
    logic [AW+3:0] w_k_ext;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_in_table   = {8'd0, r_pos} < TABLE_BYTES_W;
    assign w_next_shift = {i_data_byte, r_shift[31:8]};
    assign w_q          = r_pos - btsv_pkg::POS_ENTRIES;
    assign w_entry      = {3'd0, w_q[7:3]};
    assign w_off        = r_pos[2:0];
    assign w_entry_ok   = (r_pos >= btsv_pkg::POS_ENTRIES) && (w_entry < ENTRY_COUNT_B);
    assign w_j_next     = {1'b0, r_j} + {{AW{1'b0}}, 1'b1};
    assign w_k_ext      = {4'd0, r_k};

    // Pick the operands of the shared comparator: header/ordinal field in idle,
    // stored import against the new import during the duplicate scan.
    always_comb begin
        w_chk_en   = 1'b0;
        w_chk_code = btsv_pkg::ST_OK;
        w_cmp_a    = w_next_shift;
        w_cmp_b    = 32'd0;
        if (r_state == btsv_pkg::S_CMP) begin
            w_cmp_a = r_word;
            w_cmp_b = w_ram_rdata;
        end else if (r_pos == btsv_pkg::POS_VERSION) begin
            w_chk_en   = 1'b1;
            w_chk_code = btsv_pkg::ST_VERSION;
            w_cmp_a    = {16'd0, w_next_shift[31:16]};
            w_cmp_b    = {16'd0, r_exp_version};
        end else if (r_pos == btsv_pkg::POS_CATALOG) begin
            w_chk_en   = 1'b1;
            w_chk_code = btsv_pkg::ST_CATALOG;
            w_cmp_a    = {16'd0, w_next_shift[31:16]};
            w_cmp_b    = {16'd0, r_exp_catalog};
        end else if (r_pos == btsv_pkg::POS_COUNT) begin
            w_chk_en   = 1'b1;
            w_chk_code = btsv_pkg::ST_COUNT;
            w_cmp_b    = ENTRY_COUNT_W;
        end else if (r_pos == btsv_pkg::POS_RESERVED0 || r_pos == btsv_pkg::POS_RESERVED1) begin
            w_chk_en   = 1'b1;
            w_chk_code = btsv_pkg::ST_RESERVED;
        end else if (w_entry_ok && w_off == btsv_pkg::OFF_ORDINAL_END) begin
            w_chk_en   = 1'b1;
            w_chk_code = btsv_pkg::ST_ORDINAL;
            w_cmp_b    = {24'd0, w_entry};
        end
    end

    assign w_cmp_eq = (w_cmp_a == w_cmp_b);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btsv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, datapath updates and RAM control
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_first_err  = r_first_err;
        n_imp_err    = r_imp_err;
        n_word       = r_word;
        n_entry      = r_entry;
        n_j          = r_j;
        n_k          = r_k;
        n_fin        = r_fin;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_ord    = r_out_ord;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        o_in_ready   = 1'b0;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_entry;
        w_ram_raddr  = r_k;

        unique case (r_state)
            btsv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_pos = (r_pos == btsv_pkg::POS_MAX) ? btsv_pkg::POS_MAX : r_pos + 8'd1;
                    n_fin = i_final_byte;
                    if (w_in_table) begin
                        n_shift = w_next_shift;
                        if (w_chk_en && !w_cmp_eq && r_first_err == btsv_pkg::ST_OK) begin
                            n_first_err = w_chk_code;
                        end
                    end
                    if (w_entry_ok && w_off == btsv_pkg::OFF_IMPORT_END) begin
                        // Import complete: flag all-ones, then scan earlier imports
                        n_word  = w_next_shift;
                        n_entry = w_entry[AW-1:0];
                        n_j     = '0;
                        if (&w_next_shift) begin
                            n_imp_err = 1'b1;
                        end
                        n_state = (w_entry == 8'd0) ? btsv_pkg::S_WRITE : btsv_pkg::S_RD;
                    end else if (i_final_byte) begin
                        n_state = btsv_pkg::S_VERDICT;
                    end
                end
            end
            btsv_pkg::S_RD: begin
                w_ram_raddr = r_j;
                n_state     = btsv_pkg::S_CMP;
            end
            btsv_pkg::S_CMP: begin
                w_ram_raddr = r_j;
                if (w_cmp_eq) begin
                    n_imp_err = 1'b1;
                end
                if (w_j_next == {1'b0, r_entry}) begin
                    n_state = btsv_pkg::S_WRITE;
                end else begin
                    n_j     = w_j_next[AW-1:0];
                    n_state = btsv_pkg::S_RD;
                end
            end
            btsv_pkg::S_WRITE: begin
                w_ram_we = 1'b1;
                n_state  = r_fin ? btsv_pkg::S_VERDICT : btsv_pkg::S_IDLE;
            end
            btsv_pkg::S_VERDICT: begin
                if (w_out_free) begin
                    n_out_ord   = 4'd0;
                    n_out_value = 32'd0;
                    n_out_last  = 1'b1;
                    n_k         = '0;
                    n_state     = btsv_pkg::S_IDLE;
                    priority if ({8'd0, r_pos} != TABLE_BYTES_W) begin
                        n_out_valid  = 1'b1;
                        n_out_status = btsv_pkg::ST_SIZE;
                    end else if (r_first_err != btsv_pkg::ST_OK) begin
                        n_out_valid  = 1'b1;
                        n_out_status = r_first_err;
                    end else if (r_imp_err) begin
                        n_out_valid  = 1'b1;
                        n_out_status = btsv_pkg::ST_INDEX;
                    end else begin
                        n_state = btsv_pkg::S_ORD;
                    end
                    // Start over for the next table
                    n_pos       = 8'd0;
                    n_shift     = 32'd0;
                    n_first_err = btsv_pkg::ST_OK;
                    n_imp_err   = 1'b0;
                end
            end
            btsv_pkg::S_ORD: begin
                n_state = btsv_pkg::S_OUT;
            end
            btsv_pkg::S_OUT: begin
                // Hold the read address so the RAM data stays put while stalled
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = btsv_pkg::ST_OK;
                    n_out_ord    = w_k_ext[3:0];
                    n_out_value  = w_ram_rdata;
                    n_out_last   = (r_k == LAST_ENTRY);
                    if (r_k == LAST_ENTRY) begin
                        n_state = btsv_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = btsv_pkg::S_ORD;
                    end
                end
            end
            default: begin
                n_state = btsv_pkg::S_IDLE;
            end
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 8'd0;
            r_shift     <= 32'd0;
            r_first_err <= btsv_pkg::ST_OK;
            r_imp_err   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fin       <= 1'b0;
            r_k         <= '0;
            r_j         <= '0;
        end else begin
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_first_err <= n_first_err;
            r_imp_err   <= n_imp_err;
            r_out_valid <= n_out_valid;
            r_fin       <= n_fin;
            r_k         <= n_k;
            r_j         <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_entry      <= n_entry;
        r_out_status <= n_out_status;
        r_out_ord    <= n_out_ord;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= 16'd0;
            r_exp_catalog <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                btsv_pkg::REG_EXPECTED_VERSION: r_exp_version <= i_cfg_data;
                btsv_pkg::REG_EXPECTED_CATALOG: r_exp_catalog <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Import store
    btsv_ram #(
        .DATA_W (32),
        .DEPTH  (ENTRY_COUNT)
    ) u_import_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_word),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_ordinal = r_out_ord;
    assign o_import_value  = r_out_value;
    assign o_last_result   = r_out_last;

endmodule

`default_nettype wire

// ----- verif/btsv_checker.sv -----
//==============================================================================
// btsv_checker: result checker for the binding table stream validator
// Watches the byte, result and configuration ports, rebuilds each table's
// verdict from the accepted bytes and compares every accepted result with
// the oldest verdict still owed.
//==============================================================================

module btsv_checker #(
    parameter int ENTRY_COUNT = btsv_pkg::DEFAULT_ENTRY_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_final_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [2:0]                       i_status,
    input  logic [3:0]                       i_entry_ordinal,
    input  logic [31:0]                      i_import_value,
    input  logic                             i_last_result,
    input  logic                             i_cfg_we,
    input  logic [btsv_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [btsv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int TABLE_LEN = 16 + 8 * ENTRY_COUNT;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  ordinal;
        logic [31:0] value;
        logic        last;
    } t_verdict;

    t_verdict    owed_results[$];
    logic [15:0] want_version;
    logic [15:0] want_catalog;
    logic [7:0]  byte_count;
    logic [31:0] word_sr;
    logic [2:0]  header_err;
    logic        import_bad;
    logic [31:0] imports_seen [ENTRY_COUNT];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic t_verdict make_verdict(input logic [2:0] st, input logic [3:0] ord,
                                              input logic [31:0] val, input logic last);
        t_verdict v;
        v.status  = st;
        v.ordinal = ord;
        v.value   = val;
        v.last    = last;
        return v;
    endfunction

    // Keep only the first header or ordinal error of a table
    function automatic void note_err(input logic [2:0] code);
        if (header_err == btsv_pkg::ST_OK) header_err = code;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic fin);
        int unsigned rel;
        int unsigned entry;
        int unsigned off;
        int          j;
        if (byte_count < TABLE_LEN) begin
            word_sr = {b, word_sr[31:8]};
            if (byte_count == btsv_pkg::POS_VERSION) begin
                if (word_sr[31:16] != want_version) note_err(btsv_pkg::ST_VERSION);
            end else if (byte_count == btsv_pkg::POS_CATALOG) begin
                if (word_sr[31:16] != want_catalog) note_err(btsv_pkg::ST_CATALOG);
            end else if (byte_count == btsv_pkg::POS_COUNT) begin
                if (word_sr != ENTRY_COUNT) note_err(btsv_pkg::ST_COUNT);
            end else if (byte_count == btsv_pkg::POS_RESERVED0 ||
                         byte_count == btsv_pkg::POS_RESERVED1) begin
                if (word_sr != 32'd0) note_err(btsv_pkg::ST_RESERVED);
            end else if (byte_count >= btsv_pkg::POS_ENTRIES) begin
                rel   = byte_count - btsv_pkg::POS_ENTRIES;
                entry = rel >> 3;
                off   = rel & 7;
                if (off == btsv_pkg::OFF_ORDINAL_END) begin
                    if (word_sr != entry) note_err(btsv_pkg::ST_ORDINAL);
                end else if (off == btsv_pkg::OFF_IMPORT_END) begin
                    // compare only against imports of this same table
                    if (word_sr == 32'hFFFF_FFFF) import_bad = 1'b1;
                    for (j = 0; j < entry; j++) begin
                        if (imports_seen[j] == word_sr) import_bad = 1'b1;
                    end
                    imports_seen[entry] = word_sr;
                end
            end
        end
        if (byte_count != btsv_pkg::POS_MAX) byte_count = byte_count + 8'd1;

        if (fin) begin
            if (byte_count != TABLE_LEN) begin
                owed_results.push_back(make_verdict(btsv_pkg::ST_SIZE, 4'd0, 32'd0, 1'b1));
            end else if (header_err != btsv_pkg::ST_OK) begin
                owed_results.push_back(make_verdict(header_err, 4'd0, 32'd0, 1'b1));
            end else if (import_bad) begin
                owed_results.push_back(make_verdict(btsv_pkg::ST_INDEX, 4'd0, 32'd0, 1'b1));
            end else begin
                for (j = 0; j < ENTRY_COUNT; j++) begin
                    owed_results.push_back(make_verdict(btsv_pkg::ST_OK, 4'(j),
                                                        imports_seen[j],
                                                        j == ENTRY_COUNT - 1));
                end
            end
            byte_count = 8'd0;
            word_sr    = 32'd0;
            header_err = btsv_pkg::ST_OK;
            import_bad = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict seen;
        t_verdict owed;
        if (!i_rst_n) begin
            owed_results.delete();
            want_version = 16'd0;
            want_catalog = 16'd0;
            byte_count   = 8'd0;
            word_sr      = 32'd0;
            header_err   = btsv_pkg::ST_OK;
            import_bad   = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == btsv_pkg::REG_EXPECTED_VERSION) begin
                    want_version = i_cfg_data;
                end else if (i_cfg_index == btsv_pkg::REG_EXPECTED_CATALOG) begin
                    want_catalog = i_cfg_data;
                end
            end
            // results leaving now were loaded before any byte taken at this edge
            if (i_out_valid && i_out_ready) begin
                seen = make_verdict(i_status, i_entry_ordinal, i_import_value, i_last_result);
                if (owed_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result st=%0d ord=%0d imp=%h last=%b",
                             $time, seen.status, seen.ordinal, seen.value, seen.last);
                end else begin
                    owed = owed_results.pop_front();
                    if (seen !== owed) begin
                        fails++;
                        $display("%0t: mismatch, expected %0d/%0d/%h/%b, actual %0d/%0d/%h/%b",
                                 $time, owed.status, owed.ordinal, owed.value, owed.last,
                                 seen.status, seen.ordinal, seen.value, seen.last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) take_byte(i_data_byte, i_final_byte);
        end
        o_pending <= owed_results.size();
    end

endmodule

// ----- verif/binding_table_stream_validator_top_tb.sv -----
//==============================================================================
// binding_table_stream_validator_top_tb: table validator testbench
// Streams a clean full table, short tables and noise through the validator
// under random idling, a long result hold-off and a stretch with no idling;
// btsv_checker scores every result.
//==============================================================================

module binding_table_stream_validator_top_tb;

    localparam int ENTRIES       = btsv_pkg::DEFAULT_ENTRY_COUNT;
    localparam int TABLE_LEN     = 16 + 8 * ENTRIES;
    // Worst byte latency is the duplicate scan of the last import
    localparam int SETTLE_CYCLES = 4 * ENTRIES + 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int LONG_HOLD     = 500;
    localparam int IDLE_PCT      = 35;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [7:0]                       i_data_byte;
    logic                             i_final_byte;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [2:0]                       o_status;
    logic [3:0]                       o_entry_ordinal;
    logic [31:0]                      o_import_value;
    logic                             o_last_result;
    logic                             i_cfg_we;
    logic [btsv_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [btsv_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    int          fail_count;
    int          results_pending;
    int          cycle_count;
    int          send_idle_pct;
    int          take_idle_pct;
    int          hold_request;
    int          hold_left;
    logic [15:0] cfg_version;
    logic [15:0] cfg_catalog;
    logic [7:0]  tbl_bytes[$];

    binding_table_stream_validator_top #(
        .ENTRY_COUNT(ENTRIES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_entry_ordinal(o_entry_ordinal),
        .o_import_value (o_import_value),
        .o_last_result  (o_last_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    btsv_checker #(
        .ENTRY_COUNT(ENTRIES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_entry_ordinal(o_entry_ordinal),
        .i_import_value (o_import_value),
        .i_last_result  (o_last_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a result that never shows up ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("binding_table_stream_validator_top_tb failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    // The hold is counted here so the sender keeps running meanwhile.
    initial begin
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    task automatic push_le(input logic [31:0] w, input int nbytes);
        int k;
        for (k = 0; k < nbytes; k++) tbl_bytes.push_back(w[8*k +: 8]);
    endtask

    // Offer every byte of tbl_bytes, flag the last one. Valid is never
    // dropped after a transaction unless an idle cycle follows, so one
    // assignment per signal per edge.
    task automatic send_table();
        int n;
        for (n = 0; n < tbl_bytes.size(); n++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_data_byte  <= tbl_bytes[n];
            i_final_byte <= (n == tbl_bytes.size() - 1);
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
    endtask

    // Build a table that matches the current header settings, cut or pad
    // it to len bytes and stream it.
    task automatic run_table(input bit extremes, input int len);
        logic [31:0] imp [ENTRIES];
        int          e;
        int          j;
        bit          clash;
        for (e = 0; e < ENTRIES; e++) begin
            if (extremes && e < 2) begin
                imp[e] = (e == 0) ? 32'h0000_0000 : 32'hFFFF_FFFE;
            end else begin
                // distinct imports, biased toward the range ends
                do begin
                    case ($urandom_range(9))
                        0:       imp[e] = 32'h0000_0000;
                        1:       imp[e] = 32'hFFFF_FFFE;
                        default: imp[e] = $urandom;
                    endcase
                    clash = (imp[e] == 32'hFFFF_FFFF);
                    for (j = 0; j < e; j++) begin
                        if (imp[j] == imp[e]) clash = 1'b1;
                    end
                end while (clash);
            end
        end

        tbl_bytes.delete();
        push_le({16'd0, cfg_version}, 2);
        push_le({16'd0, cfg_catalog}, 2);
        push_le(32'(ENTRIES), 4);
        push_le(32'd0, 4);
        push_le(32'd0, 4);
        for (e = 0; e < ENTRIES; e++) begin
            push_le(32'(e), 4);
            push_le(imp[e], 4);
        end

        // bytes past the table end are never checked, so any content will do
        while (tbl_bytes.size() > len) void'(tbl_bytes.pop_back());
        while (tbl_bytes.size() < len) tbl_bytes.push_back(8'($urandom));
        send_table();
    endtask

    // Stream len random bytes as one table, always a size error
    task automatic send_noise(input int len);
        int k;
        tbl_bytes.delete();
        for (k = 0; k < len; k++) tbl_bytes.push_back(8'($urandom));
        send_table();
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet.
    // Must be entered in the step of the last byte transaction.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [15:0] ver, input logic [15:0] cat);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= btsv_pkg::REG_EXPECTED_VERSION;
        i_cfg_data  <= ver;
        @(posedge i_clk);
        i_cfg_index <= btsv_pkg::REG_EXPECTED_CATALOG;
        i_cfg_data  <= cat;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_version = ver;
        cfg_catalog = cat;
    endtask

    initial begin
        hold_request  = 0;
        send_idle_pct = IDLE_PCT;
        take_idle_pct = IDLE_PCT;
        cfg_version   = 16'd0;
        cfg_catalog   = 16'd0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'd0;
        i_final_byte <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= btsv_pkg::REG_EXPECTED_VERSION;
        i_cfg_data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short tables under random idling, header registers at reset value
        run_table(1'b0, 1);
        run_table(1'b0, 5);
        send_noise(3);

        // Hold the result side off while more tables arrive, so the output
        // register fills and the next verdict backs up into the input
        hold_request = LONG_HOLD;
        run_table(1'b0, 2);
        run_table(1'b0, 3);
        send_noise(2);

        // Wait for every owed result, then load new header settings
        settle();
        write_config(16'($urandom), 16'($urandom));

        // Full clean table with the smallest and largest legal imports and
        // a short table behind it, no idling on either side
        send_idle_pct = 0;
        take_idle_pct = 0;
        run_table(1'b1, TABLE_LEN);
        run_table(1'b0, 4);

        settle();
        send_idle_pct = IDLE_PCT;
        take_idle_pct = IDLE_PCT;
        run_table(1'b0, 6);
        send_noise(4);

        settle();
        if (fail_count == 0) begin
            $display("binding_table_stream_validator_top_tb passed");
        end else begin
            $display("binding_table_stream_validator_top_tb failed");
        end
        $finish;
    end

endmodule
